>>> rtl/core/qpi_psram_slave_core_defines.svh
// Assertion macros shared by the serial RAM slave core.
// Included by the top level; needs nothing else.
`ifndef QPI_PSRAM_SLAVE_CORE_DEFINES_SVH
`define QPI_PSRAM_SLAVE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define QPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define QPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/qps_pkg.sv
// Shared types and constants of the serial RAM slave core.
// No dependencies; imported by the top level, qps_ctrl and qps_mem.
`timescale 1ns / 1ps
`default_nettype none

package qps_pkg;

   // Memory geometry
   localparam int unsigned MemBytes = 65536;
   localparam int unsigned MemAw    = $clog2(MemBytes);
   localparam int unsigned AddrW    = 24;
   localparam logic [AddrW:0] MemLimit = (AddrW + 1)'(MemBytes);

   // Opcodes
   localparam logic [7:0] OpQuadEnter = 8'h35;
   localparam logic [7:0] OpQuadRead  = 8'hEB;
   localparam logic [7:0] OpWriteA    = 8'h02;
   localparam logic [7:0] OpWriteB    = 8'h38;

   // Nibble counter landmarks
   localparam logic [3:0] CntSpiDone  = 4'd8;
   localparam logic [3:0] CntDataBeg  = 4'd8;
   localparam logic [3:0] CntReadBeg  = 4'd13;
   localparam logic [3:0] CntLast     = 4'hF;
   localparam logic [3:0] CntWrapTo   = 4'hE;

   typedef enum logic [1:0] {
      CmdDeselect = 2'd0,
      CmdEdge     = 2'd1,
      CmdLoad     = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      StOk      = 3'd0,
      StBadOp   = 3'd1,
      StRoWrite = 3'd2,
      StWrEnd   = 3'd3,
      StRdEnd   = 3'd4
   } status_type;

   // One stored byte with its read-only flag
   typedef struct packed {
      logic       ro;
      logic [7:0] value;
   } word_type;

   // Memory requests issued by the protocol engine
   typedef struct packed {
      logic             rd_en;
      logic [MemAw-1:0] rd_addr;
      logic             data_we;
      logic [MemAw-1:0] data_waddr;
      logic [7:0]       data_wdata;
      logic             flag_we;
      logic [MemAw-1:0] flag_waddr;
   } mem_req_type;

endpackage

`default_nettype wire

>>> rtl/core/qpi_psram_slave_core.sv
// Serial RAM slave core, top level. Depends on qps_pkg, qps_ctrl, qps_mem, qps_ram.
// A result is registered and shown in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while req_ready is high; the current byte is read
// ahead from the byte and flag RAMs, so each costs one RAM read-modify-write slot.
// Reset: synchronous; then a clearing pass over all 65536 flag entries (one per cycle)
// holds req_ready low. CSR writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

`include "qpi_psram_slave_core_defines.svh"

module qpi_psram_slave_core
   import qps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input transactions
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [3:0]  req_data_in,
   input  wire logic [23:0] req_load_addr,
   input  wire logic [7:0]  req_load_byte,
   input  wire logic        req_load_ro,
   // Result transactions
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_data_out,
   output logic [2:0]       rsp_status,
   output logic             rsp_quad_active,
   // Configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_start_in_quad
);

   logic        acc;
   logic        clr_busy;
   logic        quad_set;
   mem_req_type mem_req;
   word_type    word;
   logic [3:0]  res_data_out;
   status_type  res_status;
   logic        res_quad;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_data_out_ff;
   logic [2:0]  rsp_status_ff;
   logic        rsp_quad_ff;

   // Accept while no clearing pass runs and the output register is free or draining
   assign req_ready = ~clr_busy & (~rsp_valid_ff | rsp_ready);
   assign acc       = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign quad_set  = csr_valid & csr_ready & csr_start_in_quad;

   qps_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .acc          (acc),
      .cmd          (req_cmd),
      .nib          (req_data_in),
      .load_addr    (req_load_addr),
      .load_byte    (req_load_byte),
      .load_ro      (req_load_ro),
      .quad_set     (quad_set),
      .word         (word),
      .req          (mem_req),
      .res_data_out (res_data_out),
      .res_status   (res_status),
      .res_quad     (res_quad)
   );

   qps_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .req      (mem_req),
      .word     (word),
      .clr_busy (clr_busy)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (acc) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         rsp_data_out_ff <= res_data_out;
         rsp_status_ff   <= res_status;
         rsp_quad_ff     <= res_quad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_out_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_quad_active = rsp_quad_ff;

   // Checks
   `QPS_ASSERT_NOW(a_no_item_write_in_clear, clock, reset, clr_busy, !mem_req.data_we && !mem_req.flag_we, "memory write during clearing pass")

   `QPS_ASSERT_NEXT(a_result_follows, clock, reset, acc, rsp_valid, "accepted transaction produced no result")

   `QPS_ASSERT_NEXT(a_quiet_unless_edge, clock, reset, acc && (req_cmd != CmdEdge), rsp_data_out == 4'h0, "data driven on non-edge transaction")

   `QPS_ASSERT_NOW(a_data_err_in_quad, clock, reset, rsp_valid && ((rsp_status == StRoWrite) || (rsp_status == StWrEnd) || (rsp_status == StRdEnd)), rsp_quad_active, "data-phase error outside quad mode")

endmodule

`default_nettype wire

>>> rtl/core/qps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module qps_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/core/qps_mem.sv
// Byte store and read-only flag store with clearing pass and write forwarding.
// Depends on qps_pkg and qps_ram.
`timescale 1ns / 1ps
`default_nettype none

module qps_mem
   import qps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mem_req_type req,
   output word_type         word,
   output logic             clr_busy
);

   logic             clr_busy_ff, clr_busy_in;
   logic [MemAw-1:0] clr_idx_ff, clr_idx_in;
   logic             clr_last;

   logic             pend_ff, pend_in;
   logic             pd_ff, pd_in;
   logic [7:0]       pdata_ff, pdata_in;
   logic             pf_ff, pf_in;
   logic             pflag_ff, pflag_in;
   word_type         hold_ff, hold_in;

   logic             rd_en;
   logic             f_we;
   logic [MemAw-1:0] f_waddr;
   logic             f_wdata;
   logic [7:0]       d_rdata;
   logic             f_rdata;

   // Clearing pass over the flag store after reset
   assign clr_last = (clr_idx_ff == MemAw'(MemBytes - 1));

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + MemAw'(1);
         if (clr_last) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // Reload the current word when the pass ends
   assign rd_en   = req.rd_en | (clr_busy_ff & clr_last);
   assign f_we    = clr_busy_ff | req.flag_we;
   assign f_waddr = clr_busy_ff ? clr_idx_ff : req.flag_waddr;
   assign f_wdata = ~clr_busy_ff;

   qps_ram #(
      .Width (8),
      .Depth (MemBytes)
   ) u_data_ram (
      .clock (clock),
      .we    (req.data_we),
      .waddr (req.data_waddr),
      .wdata (req.data_wdata),
      .re    (rd_en),
      .raddr (req.rd_addr),
      .rdata (d_rdata)
   );

   qps_ram #(
      .Width (1),
      .Depth (MemBytes)
   ) u_flag_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .re    (rd_en),
      .raddr (req.rd_addr),
      .rdata (f_rdata)
   );

   // Current word: fresh read data patched by same-cycle writes, else held copy
   always_comb begin
      if (pend_ff) begin
         word.ro    = pf_ff ? pflag_ff : f_rdata;
         word.value = pd_ff ? pdata_ff : d_rdata;
      end else begin
         word = hold_ff;
      end
   end

   // Capture writes that land on the address being read
   always_comb begin
      pend_in  = rd_en;
      pd_in    = req.data_we & (req.data_waddr == req.rd_addr);
      pdata_in = req.data_wdata;
      pf_in    = f_we & (f_waddr == req.rd_addr);
      pflag_in = f_wdata;
      hold_in  = word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
         pend_ff     <= 1'b0;
         pd_ff       <= 1'b0;
         pf_ff       <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
         pend_ff     <= pend_in;
         pd_ff       <= pd_in;
         pf_ff       <= pf_in;
      end
   end

   always_ff @(posedge clock) begin
      pdata_ff <= pdata_in;
      pflag_ff <= pflag_in;
      hold_ff  <= hold_in;
   end

   assign clr_busy = clr_busy_ff;

endmodule

`default_nettype wire

>>> rtl/core/qps_ctrl.sv
// Protocol engine: SPI opcode shift, quad command/address phases, write and read bursts.
// Depends on qps_pkg; talks to qps_mem through mem_req_type and word_type.
`timescale 1ns / 1ps
`default_nettype none

module qps_ctrl
   import qps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        acc,
   input  wire logic [1:0]  cmd,
   input  wire logic [3:0]  nib,
   input  wire logic [23:0] load_addr,
   input  wire logic [7:0]  load_byte,
   input  wire logic        load_ro,
   input  wire logic        quad_set,
   input  wire word_type    word,
   output mem_req_type      req,
   output logic [3:0]       res_data_out,
   output status_type       res_status,
   output logic             res_quad
);

   logic              quad_ff, quad_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [7:0]        opc_ff, opc_in;
   logic [AddrW-1:0]  addr_ff, addr_in;
   logic [3:0]        hi_ff, hi_in;
   logic [3:0]        nout_ff, nout_in;

   logic [3:0]        cnt_adv;
   logic              in_range;
   logic              load_in_range;
   logic              is_write;
   logic              is_read;
   logic [7:0]        opc_lo;
   logic [7:0]        spi_opc;
   logic [7:0]        wr_byte;
   logic              data_we;
   logic              flag_we;
   status_type        status;

   assign cnt_adv       = (cnt_ff == CntLast) ? CntWrapTo : cnt_ff + 4'd1;
   assign in_range      = ({1'b0, addr_ff} < MemLimit);
   assign load_in_range = ({1'b0, load_addr} < MemLimit);
   assign is_write      = (opc_ff == OpWriteA) || (opc_ff == OpWriteB);
   assign is_read       = (opc_ff == OpQuadRead);
   assign opc_lo        = opc_ff | {4'h0, nib};
   assign spi_opc       = {opc_ff[6:0], nib[0]};
   assign wr_byte       = {hi_ff, nib};

   // Decode one transaction
   always_comb begin
      quad_in = quad_ff;
      cnt_in  = cnt_ff;
      opc_in  = opc_ff;
      addr_in = addr_ff;
      hi_in   = hi_ff;
      nout_in = nout_ff;
      status  = StOk;
      data_we = 1'b0;
      flag_we = 1'b0;
      case (cmd_type'(cmd))
         CmdDeselect: begin
            cnt_in  = '0;
            opc_in  = '0;
            addr_in = '0;
         end
         CmdEdge: begin
            if (quad_ff) begin
               cnt_in = cnt_adv;
               if (cnt_ff == 4'd0) begin
                  opc_in = opc_ff | {nib, 4'h0};
               end else if (cnt_ff == 4'd1) begin
                  opc_in = opc_lo;
                  if ((opc_lo != OpQuadRead) && (opc_lo != OpWriteA) &&
                      (opc_lo != OpWriteB)) begin
                     status = StBadOp;
                  end
               end else if (cnt_ff < CntDataBeg) begin
                  // Address phase, most significant nibble first
                  addr_in = addr_ff | (AddrW'(nib) << {3'd7 - cnt_ff[2:0], 2'b00});
               end else if (is_write) begin
                  if (!cnt_ff[0]) begin
                     hi_in = nib;
                  end else if (!in_range) begin
                     status = StWrEnd;
                     cnt_in = cnt_ff;
                  end else if (word.ro && (word.value != wr_byte)) begin
                     status = StRoWrite;
                     cnt_in = cnt_ff;
                  end else begin
                     data_we = 1'b1;
                     addr_in = addr_ff + AddrW'(1);
                  end
               end else if (is_read && (cnt_ff >= CntReadBeg)) begin
                  if (!in_range) begin
                     status = StRdEnd;
                     cnt_in = cnt_ff;
                  end else if (cnt_ff[0]) begin
                     nout_in = word.value[7:4];
                  end else begin
                     nout_in = word.value[3:0];
                     addr_in = addr_ff + AddrW'(1);
                  end
               end
            end else if (cnt_ff < CntSpiDone) begin
               // SPI opcode, one bit per edge
               opc_in = spi_opc;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == CntSpiDone - 4'd1) begin
                  if (spi_opc == OpQuadEnter) begin
                     quad_in = 1'b1;
                  end else begin
                     status = StBadOp;
                  end
               end
            end
         end
         CmdLoad: begin
            data_we = load_in_range;
            flag_we = load_in_range & load_ro;
         end
         default: begin
         end
      endcase
   end

   // Memory requests; reload the word at the address left after this transaction
   always_comb begin
      req.rd_en      = acc;
      req.rd_addr    = addr_in[MemAw-1:0];
      req.data_we    = acc & data_we;
      req.data_waddr = (cmd_type'(cmd) == CmdLoad) ? load_addr[MemAw-1:0]
                                                   : addr_ff[MemAw-1:0];
      req.data_wdata = (cmd_type'(cmd) == CmdLoad) ? load_byte : wr_byte;
      req.flag_we    = acc & flag_we;
      req.flag_waddr = load_addr[MemAw-1:0];
   end

   assign res_data_out = (cmd_type'(cmd) == CmdEdge) ? nout_in : 4'h0;
   assign res_status   = status;
   assign res_quad     = quad_in;

   // Advance state on each accepted transaction; mode switch from the CSR
   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff <= 1'b0;
         cnt_ff  <= '0;
         opc_ff  <= '0;
         addr_ff <= '0;
         hi_ff   <= '0;
         nout_ff <= '0;
      end else begin
         if (acc) begin
            cnt_ff  <= cnt_in;
            opc_ff  <= opc_in;
            addr_ff <= addr_in;
            hi_ff   <= hi_in;
            nout_ff <= nout_in;
         end
         quad_ff <= (acc ? quad_in : quad_ff) | quad_set;
      end
   end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking bench for the quad serial RAM slave core (qpi_psram_slave_core).
// Needs qps_pkg for opcodes, command and status codes; drives random and directed
// traffic and compares every result against an in-bench model of the protocol engine.
`timescale 1ns / 1ps

module tb_top;
   import qps_pkg::*;

   // Command code with no meaning to the core; it must be ignored
   localparam logic [1:0] CmdNone = 2'd3;

   localparam int LowBytes     = 48;      // preloaded window at the bottom of memory
   localparam int TopBytes     = 16;      // preloaded window just below the end
   localparam int ReadCap      = 12;      // longest read burst, in bytes
   localparam int SettleCycles = 4;
   localparam int CycleLimit   = 400000;  // clearing pass plus a wide margin

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  data_in;
      logic [23:0] load_addr;
      logic [7:0]  load_byte;
      logic        load_ro;
   } psram_req_type;

   typedef struct packed {
      logic [3:0] data_out;
      logic [2:0] status;
      logic       quad_active;
   } psram_rsp_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = '0;
   logic [3:0]  req_data_in = '0;
   logic [23:0] req_load_addr = '0;
   logic [7:0]  req_load_byte = '0;
   logic        req_load_ro = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_data_out;
   logic [2:0]  rsp_status;
   logic        rsp_quad_active;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_start_in_quad = 1'b0;

   qpi_psram_slave_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_data_in       (req_data_in),
      .req_load_addr     (req_load_addr),
      .req_load_byte     (req_load_byte),
      .req_load_ro       (req_load_ro),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_out      (rsp_data_out),
      .rsp_status        (rsp_status),
      .rsp_quad_active   (rsp_quad_active),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_start_in_quad (csr_start_in_quad)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Protocol model state
   // ---------------------------------------------------------------
   logic       psram_quad = 1'b0;
   logic [3:0] psram_cnt = '0;
   logic [7:0] psram_opcode = '0;
   logic [23:0] psram_addr = '0;
   logic [3:0] psram_hi = '0;
   logic [3:0] psram_out = '0;
   logic [7:0] psram_mem [MemBytes];
   bit         psram_ro [MemBytes];

   // Stimulus-side knowledge of memory, used to keep reads on written bytes
   bit         plan_written [MemBytes];
   bit         plan_ro [MemBytes];
   logic [7:0] plan_mem [MemBytes];
   int         planned_items = 0;

   psram_req_type bus_items [$];
   psram_rsp_type owed_rsps [$];
   psram_req_type drive_item;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_taken = 0;
   int rsps_checked = 0;
   int mismatch_count = 0;
   int status_tally [5];
   int cycle_count = 0;

   // Advance the nibble counter; a long burst wraps 15 back to 14
   function automatic void bump_count();
      psram_cnt = (psram_cnt >= CntLast) ? CntWrapTo : psram_cnt + 4'd1;
   endfunction

   // One serial clock edge in quad mode
   function automatic status_type quad_nibble(input logic [3:0] nib);
      logic [3:0] n;
      logic [7:0] b;
      n = psram_cnt;
      if (n == 4'd0)
         psram_opcode = psram_opcode | {nib, 4'h0};
      if (n == 4'd1) begin
         psram_opcode = psram_opcode | {4'h0, nib};
         if (psram_opcode != OpQuadRead && psram_opcode != OpWriteA &&
             psram_opcode != OpWriteB) begin
            bump_count();
            return StBadOp;
         end
      end
      if (n >= 4'd2 && n <= 4'd7)
         psram_addr = psram_addr | (24'(nib) << ((7 - n) * 4));
      // Write data: latch the high nibble, store on the low one
      if (n >= CntDataBeg && (psram_opcode == OpWriteA || psram_opcode == OpWriteB)) begin
         if (!n[0]) begin
            psram_hi = nib;
         end else begin
            b = {psram_hi, nib};
            if (psram_addr >= MemBytes)
               return StWrEnd;
            if (psram_ro[psram_addr[MemAw-1:0]] && psram_mem[psram_addr[MemAw-1:0]] != b)
               return StRoWrite;
            psram_mem[psram_addr[MemAw-1:0]] = b;
            psram_addr = psram_addr + 24'd1;
         end
      end
      // Read data: high nibble on odd counts, low nibble and advance on even
      if (n >= CntReadBeg && psram_opcode == OpQuadRead) begin
         if (psram_addr >= MemBytes)
            return StRdEnd;
         if (n[0]) begin
            psram_out = psram_mem[psram_addr[MemAw-1:0]][7:4];
         end else begin
            psram_out = psram_mem[psram_addr[MemAw-1:0]][3:0];
            psram_addr = psram_addr + 24'd1;
         end
      end
      bump_count();
      return StOk;
   endfunction

   // One serial clock edge in single-bit mode
   function automatic status_type spi_bit(input logic bit_in);
      if (psram_cnt >= CntSpiDone)
         return StOk;
      psram_opcode = {psram_opcode[6:0], bit_in};
      psram_cnt = psram_cnt + 4'd1;
      if (psram_cnt == CntSpiDone) begin
         if (psram_opcode == OpQuadEnter) begin
            psram_quad = 1'b1;
            return StOk;
         end
         return StBadOp;
      end
      return StOk;
   endfunction

   // Result of one accepted transaction
   function automatic psram_rsp_type step_psram(input psram_req_type it);
      psram_rsp_type r;
      r.data_out = '0;
      r.status = StOk;
      case (it.cmd)
         CmdDeselect: begin
            psram_cnt = '0;
            psram_opcode = '0;
            psram_addr = '0;
         end
         CmdEdge: begin
            r.status = psram_quad ? quad_nibble(it.data_in) : spi_bit(it.data_in[0]);
            r.data_out = psram_out;
         end
         CmdLoad: begin
            if (it.load_addr < MemBytes) begin
               psram_mem[it.load_addr[MemAw-1:0]] = it.load_byte;
               if (it.load_ro)
                  psram_ro[it.load_addr[MemAw-1:0]] = 1'b1;
            end
         end
         default: ;
      endcase
      r.quad_active = psram_quad;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic queue_req(input logic [1:0] cmd, input logic [3:0] din,
                            input logic [23:0] la, input logic [7:0] lb, input logic ro);
      psram_req_type it;
      it = '{cmd: cmd, data_in: din, load_addr: la, load_byte: lb, load_ro: ro};
      bus_items.push_back(it);
      if (cmd == CmdLoad && la < MemBytes) begin
         plan_written[la[MemAw-1:0]] = 1'b1;
         plan_mem[la[MemAw-1:0]] = lb;
         if (ro)
            plan_ro[la[MemAw-1:0]] = 1'b1;
      end
      // Ignored transactions do not count toward the stimulus size
      if (cmd != CmdNone && !(cmd == CmdLoad && la >= MemBytes))
         planned_items++;
   endtask

   task automatic queue_edge(input logic [3:0] nib);
      queue_req(CmdEdge, nib, 24'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic queue_deselect();
      queue_req(CmdDeselect, 4'($urandom), 24'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic queue_preload(input logic [23:0] la, input logic [7:0] lb, input logic ro);
      queue_req(CmdLoad, 4'($urandom), la, lb, ro);
   endtask

   task automatic queue_spi_byte(input logic [7:0] value);
      int i;
      for (i = 7; i >= 0; i--)
         queue_edge({3'($urandom), value[i]});
   endtask

   // Select, opcode nibbles, then the first naddr address nibbles
   task automatic queue_header(input logic [7:0] op, input logic [23:0] a, input int naddr);
      int i;
      queue_deselect();
      queue_edge(op[7:4]);
      queue_edge(op[3:0]);
      for (i = 0; i < naddr; i++)
         queue_edge(a[23 - 4 * i -: 4]);
   endtask

   function automatic logic [23:0] pick_addr();
      int sel;
      sel = $urandom_range(99);
      if (sel < 45)
         return 24'($urandom_range(LowBytes - 1));
      if (sel < 75)
         return 24'(MemBytes - $urandom_range(1, TopBytes));
      if (sel < 90)
         return 24'(MemBytes + $urandom_range(2));
      return 24'($urandom_range(MemBytes, 24'hFF_FFFF));
   endfunction

   // Bytes that a read from this address may touch without hitting unwritten memory
   function automatic int readable_run(input logic [23:0] a);
      int r;
      for (r = 0; r < ReadCap; r++) begin
         if (a + r >= MemBytes)
            return ReadCap;
         if (!plan_written[a + r])
            return r;
      end
      return ReadCap;
   endfunction

   task automatic queue_random_sequence();
      int kind, i, nbytes, nnib;
      logic [23:0] a;
      logic [7:0] op, b;
      kind = $urandom_range(99);
      a = pick_addr();
      if (kind < 35) begin
         // Write burst; read-only bytes often get their own value back
         op = $urandom_range(1) ? OpWriteA : OpWriteB;
         queue_header(op, a, 6);
         nbytes = $urandom_range(1, 6);
         for (i = 0; i < nbytes; i++) begin
            b = 8'($urandom);
            if (a + i < MemBytes && plan_ro[a + i] && $urandom_range(1))
               b = plan_mem[a + i];
            queue_edge(b[7:4]);
            queue_edge(b[3:0]);
         end
         if ($urandom_range(9) == 0)
            queue_edge(4'($urandom));
      end else if (kind < 70) begin
         // Read burst with five dummy edges ahead of the data
         queue_header(OpQuadRead, a, 6);
         for (i = 0; i < 5; i++)
            queue_edge(4'($urandom));
         nnib = $urandom_range(2 * readable_run(a));
         for (i = 0; i < nnib; i++)
            queue_edge(4'($urandom));
      end else if (kind < 78) begin
         // Unsupported opcode, then a few dead edges
         do op = 8'($urandom);
         while (op == OpQuadRead || op == OpWriteA || op == OpWriteB);
         queue_header(op, 24'($urandom), 6);
         nnib = $urandom_range(4);
         for (i = 0; i < nnib; i++)
            queue_edge(4'($urandom));
      end else if (kind < 88) begin
         // Header cut short by the next deselect
         op = ($urandom_range(2) == 0) ? OpQuadRead : OpWriteA;
         queue_header(op, a, $urandom_range(5));
      end else begin
         // Background noise between selections
         i = $urandom_range(3);
         if (i == 0)
            queue_req(CmdNone, 4'($urandom), 24'($urandom), 8'($urandom), 1'($urandom));
         else if (i == 1)
            queue_preload(24'($urandom), 8'($urandom), 1'($urandom));
         else if (i == 2)
            queue_preload(pick_addr(), 8'($urandom), $urandom_range(3) == 0);
         else
            queue_deselect();
      end
   endtask

   // Single register write; the model takes it at the handshake
   task automatic write_start_in_quad(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_start_in_quad <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (value)
         psram_quad = 1'b1;
   endtask

   // Wait until every transaction is sent and every result has come back
   task automatic drain();
      do @(negedge clock);
      while (bus_items.size() != 0 || req_valid || owed_rsps.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Driver: present queued transactions, predict on acceptance
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            owed_rsps.push_back(step_psram(drive_item));
            items_taken++;
         end
         if (!req_valid || req_ready) begin
            if (bus_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_item = bus_items.pop_front();
               req_valid <= 1'b1;
               req_cmd <= drive_item.cmd;
               req_data_in <= drive_item.data_in;
               req_load_addr <= drive_item.load_addr;
               req_load_byte <= drive_item.load_byte;
               req_load_ro <= drive_item.load_ro;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: compare each result with the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      psram_rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_rsps.size() == 0) begin
               $display({"%0t unexpected result: expected none, ",
                         "got data_out %0h status %0d quad %0b"},
                        $time, rsp_data_out, rsp_status, rsp_quad_active);
               mismatch_count++;
            end else begin
               exp_rsp = owed_rsps.pop_front();
               rsps_checked++;
               status_tally[exp_rsp.status]++;
               if (rsp_data_out !== exp_rsp.data_out) begin
                  $display("%0t data_out mismatch: expected %0h, got %0h",
                           $time, exp_rsp.data_out, rsp_data_out);
                  mismatch_count++;
               end
               if (rsp_status !== exp_rsp.status) begin
                  $display("%0t status mismatch: expected %0d, got %0d",
                           $time, exp_rsp.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_quad_active !== exp_rsp.quad_active) begin
                  $display("%0t quad_active mismatch: expected %0b, got %0b",
                           $time, exp_rsp.quad_active, rsp_quad_active);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, owed_rsps.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      int i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_start_in_quad(1'b0);

      @(negedge clock);
      send_idle_pct = 37;
      recv_idle_pct = 46;

      // Directed: ignored code, out-of-range and edge preloads, bad SPI opcode,
      // extra SPI bits, switch to quad, and an edge right after the switch
      queue_req(CmdNone, 4'hF, 24'hFF_FFFF, 8'hFF, 1'b1);
      queue_preload(24'hFF_FFFF, 8'hFF, 1'b1);
      queue_preload(24'(MemBytes - 1), 8'h00, 1'b0);
      queue_preload(24'h00_0000, 8'hFF, 1'b1);
      queue_spi_byte(8'hA5);
      queue_edge(4'hF);
      queue_deselect();
      queue_spi_byte(OpQuadEnter);
      queue_edge(4'h0);

      // Fill both readable windows, a quarter of the bytes read-only
      for (i = 0; i < LowBytes; i++)
         queue_preload(24'(i), 8'($urandom), $urandom_range(3) == 0);
      for (i = MemBytes - TopBytes; i < MemBytes; i++)
         queue_preload(24'(i), 8'($urandom), $urandom_range(3) == 0);

      while (planned_items < 330)
         queue_random_sequence();
      drain();

      // Swap idling and set the register
      write_start_in_quad(1'b1);
      @(negedge clock);
      send_idle_pct = 46;
      recv_idle_pct = 37;
      while (planned_items < 640)
         queue_random_sequence();
      drain();

      // Full rate both ways, register written with 0 again (quad mode stays on)
      write_start_in_quad(1'b0);
      @(negedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (planned_items < 950)
         queue_random_sequence();
      drain();

      $display("summary: %0d transactions sent, %0d results checked, %0d mismatches",
               items_taken, rsps_checked, mismatch_count);
      $display("summary: ok %0d, bad opcode %0d, read-only hit %0d, write end %0d, read end %0d",
               status_tally[StOk], status_tally[StBadOp], status_tally[StRoWrite],
               status_tally[StWrEnd], status_tally[StRdEnd]);
      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/qps_pkg.sv
rtl/core/qps_ram.sv
rtl/core/qps_mem.sv
rtl/core/qps_ctrl.sv
rtl/core/qpi_psram_slave_core.sv
sim/tb_top.sv
